[rtl/pidr_pkg.sv]
// Shared types and constants for the PID controller with integral-reset anti-windup.
// Used by pidr_mac and by the top level pid_with_reset_antiwindup_unit.
// Depends on nothing.
package pidr_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_PERIOD      = 3'd3;
  localparam logic [2:0] REG_OUT_LIMIT   = 3'd4;

  localparam int GAIN_WIDTH  = 16;
  localparam int LIMIT_WIDTH = 15;
  localparam int CHUNK_WIDTH = 16;

  // Reset values of the configuration registers.
  localparam logic [GAIN_WIDTH-1:0]  PROP_GAIN_RST  = 16'd1016;
  localparam logic [GAIN_WIDTH-1:0]  INTEG_GAIN_RST = 16'd69;
  localparam logic [GAIN_WIDTH-1:0]  DERIV_GAIN_RST = 16'd30336;
  localparam logic [GAIN_WIDTH-1:0]  PERIOD_RST     = 16'd2185;
  localparam logic [LIMIT_WIDTH-1:0] OUT_LIMIT_RST  = 15'd2240;

  // Binary point positions used when the products are combined.
  localparam int INC_SHIFT   = 6;
  localparam int ITERM_SHIFT = 10;
  localparam int OUT_SHIFT   = 8;

  // Request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic                  start;
    logic [GAIN_WIDTH-1:0] gain;
  } mac_req_t;

endpackage

[rtl/pidr_mac.sv]
// Shared multiplier: signed operand times unsigned 16-bit gain, 16 operand bits per cycle.
// Partial products are accumulated most significant chunk first (Horner form).
// Depends on pidr_pkg.
module pidr_mac #(
  parameter int NCH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pidr_pkg::mac_req_t         req,
  input  logic [NCH*16-1:0]          opnd,
  output logic signed [NCH*16+17:0]  prod,
  output logic                       done
);

  localparam int XW = NCH * pidr_pkg::CHUNK_WIDTH;
  localparam int AW = XW + 18;
  localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;

  logic [XW-1:0]                    x_reg;
  logic [pidr_pkg::GAIN_WIDTH-1:0]  g_reg;
  logic                             act;
  logic                             first;
  logic [CW-1:0]                    cnt;

  logic signed [33:0]               pp;
  logic                             pp_vld;
  logic                             pp_first;
  logic                             pp_last;

  logic [15:0]                      chunk;
  logic signed [16:0]               chunk_ext;
  logic signed [16:0]               gain_ext;
  logic signed [AW-1:0]             acc;
  logic signed [AW-1:0]             acc_next;

  assign chunk     = x_reg[XW-1 -: 16];
  // Only the top chunk carries the sign; lower chunks are plain magnitudes.
  assign chunk_ext = $signed({chunk[15] & first, chunk});
  assign gain_ext  = $signed({1'b0, g_reg});
  assign acc_next  = (pp_first ? AW'(0) : (acc <<< 16)) + AW'(pp);

  always_ff @(posedge clk) begin
    if (rst) begin
      act    <= 1'b0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      if (req.start) begin
        act <= 1'b1;
      end else if (act && cnt == '0) begin
        act <= 1'b0;
      end
      pp_vld <= act;
      done   <= pp_vld && pp_last;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_reg <= opnd;
      g_reg <= req.gain;
      cnt   <= CW'(NCH - 1);
      first <= 1'b1;
    end else if (act) begin
      x_reg <= x_reg << 16;
      cnt   <= cnt - 1'b1;
      first <= 1'b0;
    end
    if (act) begin
      pp       <= chunk_ext * gain_ext;
      pp_first <= first;
      pp_last  <= (cnt == '0);
    end
    if (pp_vld) begin
      acc <= acc_next;
    end
  end

  assign prod = acc;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !act)
    else $error("mac started while busy");

  a_start_act: assert property (@(posedge clk) disable iff (rst)
    req.start |=> act)
    else $error("mac did not begin after a start");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("mac done lasted more than one cycle");

endmodule

[rtl/pid_with_reset_antiwindup_unit.sv]
// PID controller with anti-windup by integral reset: top level and sequencer.
// Depends on pidr_pkg and pidr_mac.
//
// Usage: one input beat (target_value, measured_value) is one control tick.
// The block forms the error, updates the saturating integral, and returns one
// output beat (drive_value, limited) per tick on the out channel.
// All four products (error*period, kp*error, kd_rate*delta, ki*integral) go
// through one shared 17x17 multiplier that takes 16 operand bits per cycle,
// NCH = ceil(max(SAMPLE_WIDTH+2, INTEGRAL_WIDTH)/16) chunks per product.
// A beat reaches out_valid once all four products and the final output step
// are done, and in_ready returns in that same cycle; a new beat is taken
// only after the previous tick has finished. in_ready is high only while
// the sequencer is idle.
// The result sits in an output register: a new beat is accepted while an
// earlier result waits, but a finished tick waits for that register to empty.
// Reset (synchronous, active high) restores the gain, period and limit
// registers to their defaults and clears the integral, previous error and
// saturated flag. Configuration writes belong in idle periods with no tick in flight.
module pid_with_reset_antiwindup_unit #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [2:0]                        cfg_index,
  input  logic [pidr_pkg::GAIN_WIDTH-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    target_value,
  input  logic signed [SAMPLE_WIDTH-1:0]    measured_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    drive_value,
  output logic                              limited
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int IW   = INTEGRAL_WIDTH;
  localparam int OPW  = (SW + 2 > IW) ? SW + 2 : IW;
  localparam int NCH  = (OPW + 15) / 16;
  localparam int XW   = NCH * 16;
  localparam int AW   = XW + 18;
  localparam int SUMW = AW + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INC  = 3'd1;
  localparam logic [2:0] ST_PROP = 3'd2;
  localparam logic [2:0] ST_DER  = 3'd3;
  localparam logic [2:0] ST_INT  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [pidr_pkg::GAIN_WIDTH-1:0]  prop_gain;
  logic [pidr_pkg::GAIN_WIDTH-1:0]  integral_gain;
  logic [pidr_pkg::GAIN_WIDTH-1:0]  deriv_rate_gain;
  logic [pidr_pkg::GAIN_WIDTH-1:0]  sample_period;
  logic [pidr_pkg::LIMIT_WIDTH-1:0] output_limit;

  logic signed [IW-1:0]   integral_sum;
  logic signed [SW:0]     last_error;
  logic                   was_limited;
  logic signed [SW:0]     err;
  logic signed [SUMW-1:0] acc_sum;

  logic signed [SW:0]     err_in;
  logic signed [SW+1:0]   delta_err;
  pidr_pkg::mac_req_t     mac_req;
  logic [XW-1:0]          mac_opnd;
  logic signed [AW-1:0]   mac_prod;
  logic                   mac_done;

  logic signed [AW-1:0]   inc;
  logic signed [SUMW-1:0] isum;
  logic signed [SUMW-1:0] imax_w;
  logic signed [SUMW-1:0] imin_w;
  logic signed [SUMW-1:0] isum_sat;
  logic signed [SUMW-1:0] outv;
  logic signed [SUMW-1:0] lim_w;
  logic signed [SUMW-1:0] neg_lim;
  logic                   clamp;
  logic signed [SUMW-1:0] drive_next;
  logic                   out_free;

  assign err_in    = (SW + 1)'(target_value) - (SW + 1)'(measured_value);
  assign delta_err = (SW + 2)'(err) - (SW + 2)'(last_error);
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  // Integral update with saturation at the register width.
  assign inc      = mac_prod >>> pidr_pkg::INC_SHIFT;
  assign isum     = SUMW'(integral_sum) + SUMW'(inc);
  assign imax_w   = $signed({{(SUMW - IW + 1){1'b0}}, {(IW - 1){1'b1}}});
  assign imin_w   = ~imax_w;
  assign isum_sat = (isum > imax_w) ? imax_w : ((isum < imin_w) ? imin_w : isum);

  // Output scaling and magnitude clamp.
  assign outv       = acc_sum >>> pidr_pkg::OUT_SHIFT;
  assign lim_w      = $signed(SUMW'(output_limit));
  assign neg_lim    = -lim_w;
  assign clamp      = (outv > lim_w) || (outv < neg_lim);
  assign drive_next = clamp ? (outv[SUMW-1] ? neg_lim : lim_w) : outv;

  pidr_mac #(
    .NCH (NCH)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .req  (mac_req),
    .opnd (mac_opnd),
    .prod (mac_prod),
    .done (mac_done)
  );

  // Sequencer: each product state but the last launches the next product when the current one ends.
  always_comb begin
    state_next    = state;
    mac_req.start = 1'b0;
    mac_req.gain  = '0;
    mac_opnd      = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          mac_req.start = 1'b1;
          mac_req.gain  = sample_period;
          mac_opnd      = XW'(err_in);
          state_next    = ST_INC;
        end
      end
      ST_INC: begin
        if (mac_done) begin
          mac_req.start = 1'b1;
          mac_req.gain  = prop_gain;
          mac_opnd      = XW'(err);
          state_next    = ST_PROP;
        end
      end
      ST_PROP: begin
        if (mac_done) begin
          mac_req.start = 1'b1;
          mac_req.gain  = deriv_rate_gain;
          mac_opnd      = XW'(delta_err);
          state_next    = ST_DER;
        end
      end
      ST_DER: begin
        if (mac_done) begin
          // The integral term is dropped after a saturated tick.
          mac_req.start = 1'b1;
          mac_req.gain  = was_limited ? '0 : integral_gain;
          mac_opnd      = XW'(integral_sum);
          state_next    = ST_INT;
        end
      end
      ST_INT: begin
        if (mac_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      prop_gain       <= pidr_pkg::PROP_GAIN_RST;
      integral_gain   <= pidr_pkg::INTEG_GAIN_RST;
      deriv_rate_gain <= pidr_pkg::DERIV_GAIN_RST;
      sample_period   <= pidr_pkg::PERIOD_RST;
      output_limit    <= pidr_pkg::OUT_LIMIT_RST;
      integral_sum    <= '0;
      last_error      <= '0;
      was_limited     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          pidr_pkg::REG_PROP_GAIN:  prop_gain       <= cfg_data;
          pidr_pkg::REG_INTEG_GAIN: integral_gain   <= cfg_data;
          pidr_pkg::REG_DERIV_GAIN: deriv_rate_gain <= cfg_data;
          pidr_pkg::REG_PERIOD:     sample_period   <= cfg_data;
          pidr_pkg::REG_OUT_LIMIT:  output_limit    <= cfg_data[pidr_pkg::LIMIT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (state == ST_INC && mac_done) begin
        integral_sum <= isum_sat[IW-1:0];
      end
      if (state == ST_FIN && out_free) begin
        out_valid   <= 1'b1;
        was_limited <= clamp;
        last_error  <= err;
        if (clamp) begin
          integral_sum <= '0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      err <= err_in;
    end
    if (mac_done) begin
      unique case (state)
        ST_PROP: acc_sum <= SUMW'(mac_prod);
        ST_DER:  acc_sum <= acc_sum + SUMW'(mac_prod);
        ST_INT:  acc_sum <= acc_sum + SUMW'(mac_prod >>> pidr_pkg::ITERM_SHIFT);
        default: ;
      endcase
    end
    if (state == ST_FIN && out_free) begin
      drive_value <= drive_next[SW-1:0];
      limited     <= clamp;
    end
  end

  logic [SW-1:0] lim_pos;
  logic [SW-1:0] lim_neg;
  assign lim_pos = lim_w[SW-1:0];
  assign lim_neg = neg_lim[SW-1:0];

  // The multiplier never reports a product while the sequencer is idle.
  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mac_done)
    else $error("product finished with no tick in progress");

  // A clamped result carries exactly the limit magnitude.
  a_limit_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && limited) |-> (drive_value == lim_pos || drive_value == lim_neg))
    else $error("clamped output differs from the limit");

  // After a saturated tick the integral stays cleared until the next tick starts.
  a_windup_clear: assert property (@(posedge clk) disable iff (rst)
    (was_limited && state == ST_IDLE) |-> (integral_sum == '0))
    else $error("integral not cleared after saturation");

  // An accepted beat always starts with the integral increment.
  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_INC))
    else $error("tick did not start with the integral product");

endmodule

[verif/pid_with_reset_antiwindup_unit_tb.sv]
// Self-checking testbench for the PID controller with integral-reset anti-windup.
// Needs rtl/pidr_pkg.sv and the pid_with_reset_antiwindup_unit RTL; a built-in
// predictor computes each expected drive beat, and a monitor checks every output beat.
module pid_with_reset_antiwindup_unit_tb;

  localparam int CLK_HALF = 5;
  localparam int SETTLE_CYCLES = 24;
  localparam int RUN_LIMIT = 10_000_000;
  localparam int PHASE_ITEMS = 260;

  localparam int RX_ALWAYS = 0;
  localparam int RX_MOSTLY = 1;
  localparam int RX_SPARSE = 2;

  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               limited;
  } drive_beat_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [pidr_pkg::GAIN_WIDTH-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] target_value;
  logic signed [15:0] measured_value;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] drive_value;
  logic limited;

  // Controller copy kept by the testbench: registers and loop state.
  longint kp_gain, ki_gain, kd_gain, period_q16, limit_q6;
  longint integ_acc, prev_err;
  bit prev_clamped;

  drive_beat_t pending_drive[$];
  int errors_seen = 0;
  int burst_left = 0;
  int walk_sp = 0;

  pid_with_reset_antiwindup_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .target_value(target_value),
    .measured_value(measured_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive_value(drive_value),
    .limited(limited)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic drive_beat_t control_tick(input logic signed [15:0] tgt,
                                               input logic signed [15:0] meas);
    longint err, inc, p_term, d_term, i_term, total, outv;
    bit clamp;
    drive_beat_t beat;
    err = longint'(tgt) - longint'(meas);
    inc = (err * period_q16) >>> pidr_pkg::INC_SHIFT;
    integ_acc = integ_acc + inc;
    if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
    if (integ_acc < INTEG_MIN) integ_acc = INTEG_MIN;
    p_term = kp_gain * err;
    d_term = kd_gain * (err - prev_err);
    i_term = prev_clamped ? 64'sd0 : ki_gain * integ_acc;
    total = p_term + d_term + (i_term >>> pidr_pkg::ITERM_SHIFT);
    outv = total >>> pidr_pkg::OUT_SHIFT;
    clamp = (outv > limit_q6) || (outv < -limit_q6);
    if (clamp) begin
      outv = (outv >= 0) ? limit_q6 : -limit_q6;
      integ_acc = 0;
    end
    prev_clamped = clamp;
    prev_err = err;
    beat.drive = outv[15:0];
    beat.limited = clamp;
    return beat;
  endfunction

  task automatic write_reg(input logic [2:0] idx,
                           input logic [pidr_pkg::GAIN_WIDTH-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      pidr_pkg::REG_PROP_GAIN:  kp_gain = data;
      pidr_pkg::REG_INTEG_GAIN: ki_gain = data;
      pidr_pkg::REG_DERIV_GAIN: kd_gain = data;
      pidr_pkg::REG_PERIOD:     period_q16 = data;
      pidr_pkg::REG_OUT_LIMIT:  limit_q6 = data[pidr_pkg::LIMIT_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd, input logic [15:0] period,
                               input logic [15:0] lim);
    write_reg(pidr_pkg::REG_PROP_GAIN, kp);
    write_reg(pidr_pkg::REG_INTEG_GAIN, ki);
    write_reg(pidr_pkg::REG_DERIV_GAIN, kd);
    write_reg(pidr_pkg::REG_PERIOD, period);
    write_reg(pidr_pkg::REG_OUT_LIMIT, lim);
  endtask

  // Sends one tick. The sender runs in bursts; valid drops only inside a gap.
  task automatic send_tick(input logic signed [15:0] tgt, input logic signed [15:0] meas);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    target_value <= tgt;
    measured_value <= meas;
    do @(posedge clk); while (!in_ready);
    pending_drive.push_back(control_tick(tgt, meas));
  endtask

  // Lowers valid, waits for every outstanding beat, then lets the sequencer go idle.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Mostly a wandering setpoint with a measurement close to it, plus steps and noise.
  task automatic random_tick();
    int style, t, m;
    style = $urandom_range(0, 9);
    walk_sp = walk_sp + int'($urandom_range(0, 512)) - 256;
    if (walk_sp > 32767) walk_sp = 32767;
    if (walk_sp < -32768) walk_sp = -32768;
    if (style < 6) begin
      t = walk_sp;
      m = t + int'($urandom_range(0, 128)) - 64;
    end else if (style < 8) begin
      t = int'($urandom_range(0, 65535)) - 32768;
      m = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      t = walk_sp;
      m = t + int'($urandom_range(0, 4095)) - 2048;
    end
    send_tick(clip16(t), clip16(m));
  endtask

  task automatic test_input_extremes();
    settle();
    load_settings(pidr_pkg::PROP_GAIN_RST, pidr_pkg::INTEG_GAIN_RST,
                  pidr_pkg::DERIV_GAIN_RST, pidr_pkg::PERIOD_RST,
                  {1'b0, pidr_pkg::OUT_LIMIT_RST});
    send_tick(16'sd32767, -16'sd32768);
    send_tick(-16'sd32768, 16'sd32767);
    send_tick(16'sd0, 16'sd0);
    send_tick(-16'sd32768, -16'sd32768);
    send_tick(16'sd32767, 16'sd32767);
    send_tick(16'sd100, 16'sd90);
  endtask

  task automatic test_output_clamp();
    settle();
    write_reg(pidr_pkg::REG_OUT_LIMIT, 16'd0);
    // With a zero limit only an exact zero output escapes the clamp.
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd300, 16'sd0);
    send_tick(-16'sd300, 16'sd0);
    settle();
    write_reg(pidr_pkg::REG_OUT_LIMIT, 16'd100);
    send_tick(16'sd2000, 16'sd0);
    send_tick(-16'sd2000, 16'sd0);
    settle();
    // The top data bit lies above the limit register and must be dropped.
    write_reg(pidr_pkg::REG_OUT_LIMIT, 16'hFFFF);
    send_tick(16'sd32767, -16'sd32768);
    send_tick(-16'sd32768, 16'sd32767);
  endtask

  task automatic test_zero_period();
    settle();
    load_settings(16'd256, 16'd256, 16'd0, 16'd0, 16'h7FFF);
    send_tick(16'sd1000, 16'sd0);
    send_tick(16'sd1000, 16'sd0);
    send_tick(-16'sd1000, 16'sd0);
  endtask

  task automatic test_register_decode();
    settle();
    load_settings(16'd512, 16'd300, 16'd1000, 16'd4000, 16'd5000);
    for (int i = pidr_pkg::REG_OUT_LIMIT + 1; i < 8; i++) write_reg(3'(i), 16'h0000);
    send_tick(16'sd400, -16'sd100);
    send_tick(16'sd200, 16'sd50);
  endtask

  task automatic test_random_extreme_settings();
    settle();
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    repeat (PHASE_ITEMS) random_tick();
    settle();
    load_settings(16'd0, 16'd0, 16'd0, 16'd1, 16'd0);
    repeat (PHASE_ITEMS / 2) random_tick();
  endtask

  task automatic test_random_settings();
    settle();
    load_settings(pidr_pkg::PROP_GAIN_RST, pidr_pkg::INTEG_GAIN_RST,
                  pidr_pkg::DERIV_GAIN_RST, pidr_pkg::PERIOD_RST,
                  {1'b0, pidr_pkg::OUT_LIMIT_RST});
    repeat (PHASE_ITEMS) random_tick();
    repeat (2) begin
      settle();
      load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
      repeat (PHASE_ITEMS / 2) random_tick();
    end
    repeat (2) begin
      settle();
      load_settings(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 512)),
                    16'($urandom_range(0, 4096)), 16'($urandom_range(1, 65535)),
                    16'($urandom_range(256, 32767)));
      repeat (PHASE_ITEMS / 2) random_tick();
    end
  endtask

  // Long runs of large same-sign errors with only a small integral gain keep the
  // output inside the limit, so the integral reaches both rails.
  task automatic test_integral_saturation();
    int sent, run;
    bit dir;
    settle();
    load_settings(16'd0, 16'($urandom_range(1, 3)), 16'd0,
                  16'($urandom_range(49152, 65535)), 16'h7FFF);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      dir = $urandom_range(0, 1);
      run = $urandom_range(20, 60);
      repeat (run) begin
        if (dir)
          send_tick(16'($urandom_range(8192, 32767)), -16'($urandom_range(8192, 32767)));
        else
          send_tick(-16'($urandom_range(8192, 32767)), 16'($urandom_range(8192, 32767)));
      end
      sent += run;
    end
  endtask

  // Output checker: each beat is matched against the oldest prediction.
  always @(posedge clk) begin
    drive_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        $error("unexpected output beat: drive_value %0d, limited %0b", drive_value, limited);
        errors_seen++;
      end else begin
        want = pending_drive.pop_front();
        if (drive_value !== want.drive) begin
          $error("drive_value: expected %0d, actual %0d", want.drive, drive_value);
          errors_seen++;
        end
        if (limited !== want.limited) begin
          $error("limited: expected %0b, actual %0b", want.limited, limited);
          errors_seen++;
        end
      end
    end
  end

  // Receiver backpressure cycles through always-ready, mostly-ready and sparse spans.
  initial begin
    int rx_mode, span;
    out_ready = 1'b0;
    forever begin
      rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(negedge clk);
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = pidr_pkg::REG_PROP_GAIN;
    cfg_data = '0;
    in_valid = 1'b0;
    target_value = '0;
    measured_value = '0;
    kp_gain = pidr_pkg::PROP_GAIN_RST;
    ki_gain = pidr_pkg::INTEG_GAIN_RST;
    kd_gain = pidr_pkg::DERIV_GAIN_RST;
    period_q16 = pidr_pkg::PERIOD_RST;
    limit_q6 = pidr_pkg::OUT_LIMIT_RST;
    integ_acc = 0;
    prev_err = 0;
    prev_clamped = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first ticks run on the reset register values.
    send_tick(16'sd640, 16'sd0);
    send_tick(-16'sd64, 16'sd32);
    test_input_extremes();
    test_output_clamp();
    test_zero_period();
    test_register_decode();
    test_random_extreme_settings();
    test_random_settings();
    test_integral_saturation();
    settle();

    if (errors_seen == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
